// ===== rtl/sps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg: shared types and codes of the solenoid pulse sequencer
// Command codes, register indexes, payload structs and the default queue depth.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TICK_W     = 16;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_ON      = 2'd1;
	localparam logic [1:0] CMD_OFF     = 2'd2;
	localparam logic [1:0] CMD_INV_DIR = 2'd3;

	localparam logic [1:0] DIR_NONE    = 2'd0;
	localparam logic [1:0] DIR_INVALID = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ON_TIME      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TWO_POINT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLE = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [TICK_W-1:0] delay;
		logic [1:0]        direction;
	} in_item_t;

	typedef struct packed {
		logic       coil_on;
		logic [1:0] coil_dir;
		logic       off_event;
		logic       error;
	} out_item_t;

	typedef struct packed {
		logic [TICK_W-1:0] delay;
		logic [1:0]        dir;
	} queue_entry_t;

	typedef struct packed {
		logic              coil;
		logic [1:0]        active_dir;
		logic [TICK_W-1:0] on_left;
		logic              on_running;
	} coil_st_t;

endpackage
`default_nettype wire

// ===== rtl/solenoid_pulse_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// solenoid_pulse_sequencer: solenoid driver command sequencer
// Tick, on, off and invalidate-direction commands drive coil state, a delay
// counter, an on-time counter and a queue of delayed on requests.
// ----------------------------------------------------------------------------
// One command enters per clock; its result passes through an input register,
// one pass of counter and queue logic, and a result register. Commands stream
// back to back at one per cycle; the input side stalls only while the result
// register is full and the output stalls. Pending on requests wait in a
// QUEUE_DEPTH-entry RAM whose head entry is read in the cycle before its use,
// with a forward path for an entry written that same cycle.
// Write configuration only while no command is in flight.
module solenoid_pulse_sequencer #(
	parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire sps_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output sps_pkg::out_item_t                  out_data
);

	import sps_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW  = TICK_W + QCW;
	localparam int EW  = $bits(queue_entry_t);

	localparam logic [QAW-1:0] HEAD_LAST = QAW'(QUEUE_DEPTH - 1);
	localparam logic [QCW-1:0] COUNT_MAX = QCW'(QUEUE_DEPTH);
	localparam logic [QAW:0]   DEPTH_W   = (QAW + 1)'(QUEUE_DEPTH);

	function automatic coil_st_t energize(coil_st_t s, logic [1:0] dir, logic tp,
		logic [TICK_W-1:0] ot);
		coil_st_t r;
		r = s;
		if (!(tp && dir == s.active_dir)) begin
			r.active_dir = dir;
			r.coil       = 1'b1;
			if (ot != '0) begin
				r.on_left    = ot;
				r.on_running = 1'b1;
			end
		end
		return r;
	endfunction

	// configuration
	logic [TICK_W-1:0] on_time_q;
	logic              two_point_q;
	logic              queue_enable_q;

	// pipeline
	logic      s1_valid_q, s2_valid_q;
	in_item_t  item_s1;
	out_item_t result_s2;
	logic      adv;

	// sequencer state
	coil_st_t          cst_q, cst_d;
	logic [1:0]        pending_dir_q, pending_dir_d;
	logic [TICK_W-1:0] delay_left_q, delay_left_d;
	logic              delay_running_q, delay_running_d;
	logic [QAW-1:0]    head_q, head_d;
	logic [QCW-1:0]    count_q, count_d;
	logic [TW-1:0]     total_q, total_d;

	// queue storage
	logic           q_we;
	logic [QAW-1:0] q_waddr;
	queue_entry_t   q_wdata, q_rdata, head_entry, fwd_q;
	logic           fwd_sel_q;
	logic [EW-1:0]  ram_rdata;
	out_item_t      result_d;

	assign adv      = s1_valid_q && (!s2_valid_q || !out_stall);
	assign in_stall = s1_valid_q && s2_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q      <= '0;
			two_point_q    <= 1'b0;
			queue_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ON_TIME:      on_time_q      <= cfg_data[TICK_W-1:0];
				REG_TWO_POINT:    two_point_q    <= cfg_data[0];
				REG_QUEUE_ENABLE: queue_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				s2_valid_q <= 1'b1;
			end else if (!out_stall) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid = s2_valid_q;
	assign out_data  = result_s2;

	assign q_rdata    = queue_entry_t'(ram_rdata);
	assign head_entry = fwd_sel_q ? fwd_q : q_rdata;

	always_comb begin
		logic [1:0]        dir;
		logic [TICK_W-1:0] cnt_dec;
		logic [TW:0]       pend;
		logic [TICK_W-1:0] rel;
		logic [QAW+1:0]    wsum;
		logic              off_ev;
		logic              err;

		cst_d           = cst_q;
		pending_dir_d   = pending_dir_q;
		delay_left_d    = delay_left_q;
		delay_running_d = delay_running_q;
		head_d          = head_q;
		count_d         = count_q;
		total_d         = total_q;
		q_we            = 1'b0;
		off_ev          = 1'b0;
		err             = 1'b0;
		cnt_dec         = '0;

		dir     = (item_s1.direction == DIR_INVALID) ? DIR_NONE : item_s1.direction;
		pend    = (TW + 1)'(delay_left_q) + (TW + 1)'(total_q);
		rel     = ((TW + 1)'(item_s1.delay) >= pend)
			? TICK_W'((TW + 1)'(item_s1.delay) - pend) : '0;
		wsum    = (QAW + 2)'(head_q) + (QAW + 2)'(count_q);
		q_waddr = (wsum >= (QAW + 2)'(DEPTH_W))
			? QAW'(wsum - (QAW + 2)'(DEPTH_W)) : QAW'(wsum);
		q_wdata = '{delay: rel, dir: dir};

		unique case (item_s1.cmd)
			CMD_TICK: begin
				// on-time counter first, then the delay counter
				if (cst_q.on_running) begin
					cst_d.on_left = (cst_q.on_left != '0) ? cst_q.on_left - 1'b1 : '0;
					if (cst_d.on_left == '0) begin
						cst_d.on_running = 1'b0;
						cst_d.coil       = 1'b0;
						off_ev           = 1'b1;
					end
				end
				if (delay_running_q) begin
					cnt_dec      = (delay_left_q != '0) ? delay_left_q - 1'b1 : '0;
					delay_left_d = cnt_dec;
					if (cnt_dec == '0) begin
						delay_running_d = 1'b0;
						cst_d = energize(cst_d, pending_dir_q, two_point_q, on_time_q);
						if (queue_enable_q && count_q != '0) begin
							// pop the head entry and apply it as a fresh request
							head_d  = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
							count_d = count_q - 1'b1;
							total_d = (total_q >= TW'(head_entry.delay))
								? total_q - TW'(head_entry.delay) : '0;
							if (head_entry.delay == '0) begin
								cst_d = energize(cst_d, head_entry.dir, two_point_q, on_time_q);
							end else begin
								pending_dir_d   = head_entry.dir;
								delay_left_d    = head_entry.delay;
								delay_running_d = 1'b1;
							end
						end
					end
				end
			end
			CMD_ON: begin
				if (queue_enable_q && delay_running_q) begin
					if (count_q >= COUNT_MAX) begin
						err = 1'b1;
					end else begin
						q_we    = 1'b1;
						count_d = count_q + 1'b1;
						total_d = total_q + TW'(rel);
					end
				end else if (item_s1.delay == '0) begin
					cst_d = energize(cst_q, dir, two_point_q, on_time_q);
				end else begin
					pending_dir_d   = dir;
					delay_left_d    = item_s1.delay;
					delay_running_d = 1'b1;
				end
			end
			CMD_OFF: begin
				if (cst_q.coil) begin
					cst_d.on_running = 1'b0;
					cst_d.on_left    = '0;
					cst_d.coil       = 1'b0;
				end
			end
			CMD_INV_DIR: begin
				cst_d.active_dir = DIR_NONE;
			end
			default: ;
		endcase

		result_d.coil_on   = cst_d.coil;
		result_d.coil_dir  = cst_d.coil ? cst_d.active_dir : DIR_NONE;
		result_d.off_event = off_ev;
		result_d.error     = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q           <= '0;
			pending_dir_q   <= DIR_NONE;
			delay_left_q    <= '0;
			delay_running_q <= 1'b0;
			head_q          <= '0;
			count_q         <= '0;
			total_q         <= '0;
			fwd_sel_q       <= 1'b0;
		end else begin
			if (adv) begin
				cst_q           <= cst_d;
				pending_dir_q   <= pending_dir_d;
				delay_left_q    <= delay_left_d;
				delay_running_q <= delay_running_d;
				head_q          <= head_d;
				count_q         <= count_d;
				total_q         <= total_d;
			end
			// forward an entry written at the address being read
			fwd_sel_q <= adv && q_we && (q_waddr == (adv ? head_d : head_q));
		end
	end

	always_ff @(posedge clk) begin
		fwd_q <= q_wdata;
	end

	sps_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH),
		.AW    (QAW)
	) u_queue_ram (
		.clk   (clk),
		.we    (adv && q_we),
		.waddr (q_waddr),
		.wdata (EW'(q_wdata)),
		.raddr (adv ? head_d : head_q),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

// ===== rtl/sps_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sps_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
